// ----- rtl/acfr_pkg.sv -----
// shared types and constants for the averaging checksum frame receiver
package acfr_pkg;

  // framing constants
  localparam logic [7:0] START_BYTE   = 8'hFF;
  localparam logic [7:0] SLIDE_LENGTH = 8'd255;
  localparam logic [8:0] HEADER_BYTES = 9'd3;

  // running sum width and serial step count
  localparam int unsigned SUM_W  = 17;
  localparam int unsigned CNT_W  = 5;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);

  // frame length plus two header bytes gives the divisor
  localparam logic [8:0] DIV_OFFSET = 9'd2;

  // control sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } acfr_state_e;

  // start request to the serial adder
  typedef struct packed {
    logic start;
    logic clear;
  } acfr_add_ctrl_t;

  // status back from a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } acfr_status_t;

endpackage

// ----- rtl/average_checksum_frame_receiver.sv -----
// top level: frame sequencer, header registers and result register
//
//  channel | signals                                         | transfer
//  --------+-------------------------------------------------+---------------------
//  input   | rx_byte_i, in_valid_i, in_ready_o               | valid and ready high
//  output  | payload_byte_o, carries_byte_o, frame_end_o,    | valid and ready high
//          | frame_good_o, out_valid_o, out_ready_i          |
//  config  | cfg_we_i, cfg_wdata_i (suppress delivery)       | write enable high
//
// header bytes are taken directly in idle; the length byte runs the 17-step
// bit-serial adder on the header sum; every other payload byte but the last
// runs the adder and then the result state; the last byte runs the 17-step
// serial divider and then the result state, and a zero-length frame end goes
// straight to the result state.
// reset clears the sequencer, the frame counters and the result valid.
// a result that is not yet taken stalls the sequencer only when the next
// result is ready; input bytes are taken while that result waits.
module average_checksum_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] payload_byte_o,
  output logic       carries_byte_o,
  output logic       frame_end_o,
  output logic       frame_good_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  acfr_pkg::acfr_state_e      state_q;
  logic                       suppress_q;
  logic [8:0]                 held_q;
  logic [7:0]                 first_q, second_q, len_q;
  logic [7:0]                 res_byte_q;
  logic                       res_carries_q, res_end_q, res_good_q, res_from_div_q;
  logic                       pend_q;
  logic                       out_valid_q;
  logic [7:0]                 out_byte_q;
  logic                       out_carries_q, out_end_q, out_good_q;

  logic                       accept;
  logic [8:0]                 held_p1;
  logic                       frame_last;
  logic                       zero_good;
  logic [8:0]                 divisor;
  acfr_pkg::acfr_add_ctrl_t   add_ctrl;
  logic [7:0]                 op_a, op_b, op_c;
  logic                       div_start;
  acfr_pkg::acfr_status_t     add_status, div_status;
  logic [acfr_pkg::SUM_W-1:0] sum;
  logic                       div_match;
  logic                       out_free;

  assign in_ready_o = (state_q == acfr_pkg::ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // frame position and check decode
  always_comb begin
    held_p1    = held_q + 9'd1;
    frame_last = (held_p1 >= (acfr_pkg::HEADER_BYTES + {1'b0, len_q}));
    zero_good  = (({1'b0, first_q} + {1'b0, second_q}) < 9'd2);
    divisor    = {1'b0, len_q} + acfr_pkg::DIV_OFFSET;
  end

  // serial unit start requests
  always_comb begin
    add_ctrl  = '0;
    div_start = 1'b0;
    op_a      = rx_byte_i;
    op_b      = 8'd0;
    op_c      = 8'd0;
    if (accept) begin
      case (held_q)
        9'd0, 9'd1: begin
          add_ctrl = '0;
        end
        9'd2: begin
          if (rx_byte_i != acfr_pkg::SLIDE_LENGTH && rx_byte_i != 8'd0) begin
            add_ctrl.start = 1'b1;
            add_ctrl.clear = 1'b1;
            op_a           = first_q;
            op_b           = second_q;
            op_c           = rx_byte_i;
          end
        end
        default: begin
          if (frame_last) begin
            div_start = 1'b1;
          end else begin
            add_ctrl.start = 1'b1;
          end
        end
      endcase
    end
  end

  acfr_serial_add u_add (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (add_ctrl),
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .op_c_i   (op_c),
    .status_o (add_status),
    .sum_o    (sum)
  );

  acfr_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (divisor),
    .expect_i   (rx_byte_i),
    .status_o   (div_status),
    .match_o    (div_match)
  );

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      suppress_q <= 1'b0;
    end else if (cfg_we_i) begin
      suppress_q <= cfg_wdata_i;
    end
  end

  // frame sequencer and header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= acfr_pkg::ST_IDLE;
      held_q         <= '0;
      first_q        <= '0;
      second_q       <= '0;
      len_q          <= '0;
      pend_q         <= 1'b0;
      res_from_div_q <= 1'b0;
    end else begin
      case (state_q)
        acfr_pkg::ST_IDLE: begin
          if (accept) begin
            case (held_q)
              9'd0: begin
                if (rx_byte_i == acfr_pkg::START_BYTE) begin
                  first_q <= rx_byte_i;
                  held_q  <= 9'd1;
                end
              end
              9'd1: begin
                second_q <= rx_byte_i;
                held_q   <= 9'd2;
              end
              9'd2: begin
                if (rx_byte_i == acfr_pkg::SLIDE_LENGTH) begin
                  first_q  <= second_q;
                  second_q <= acfr_pkg::SLIDE_LENGTH;
                end else if (rx_byte_i == 8'd0) begin
                  len_q          <= rx_byte_i;
                  held_q         <= '0;
                  res_from_div_q <= 1'b0;
                  state_q        <= acfr_pkg::ST_EMIT;
                end else begin
                  len_q   <= rx_byte_i;
                  held_q  <= acfr_pkg::HEADER_BYTES;
                  pend_q  <= 1'b0;
                  state_q <= acfr_pkg::ST_ADD;
                end
              end
              default: begin
                if (frame_last) begin
                  held_q         <= '0;
                  res_from_div_q <= 1'b1;
                  state_q        <= acfr_pkg::ST_DIV;
                end else begin
                  held_q         <= held_p1;
                  pend_q         <= 1'b1;
                  res_from_div_q <= 1'b0;
                  state_q        <= acfr_pkg::ST_ADD;
                end
              end
            endcase
          end
        end
        acfr_pkg::ST_ADD: begin
          if (add_status.done) begin
            state_q <= pend_q ? acfr_pkg::ST_EMIT : acfr_pkg::ST_IDLE;
          end
        end
        acfr_pkg::ST_DIV: begin
          if (div_status.done) begin
            state_q <= acfr_pkg::ST_EMIT;
          end
        end
        acfr_pkg::ST_EMIT: begin
          if (suppress_q || out_free) begin
            state_q <= acfr_pkg::ST_IDLE;
          end
        end
        default: begin
          state_q <= acfr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // pending result fields
  always_ff @(posedge clk_i) begin
    if (accept && held_q == 9'd2) begin
      res_byte_q    <= 8'd0;
      res_carries_q <= 1'b0;
      res_end_q     <= 1'b1;
      res_good_q    <= zero_good;
    end else if (accept) begin
      res_byte_q    <= rx_byte_i;
      res_carries_q <= 1'b1;
      res_end_q     <= frame_last;
      res_good_q    <= 1'b0;
    end else if (state_q == acfr_pkg::ST_DIV && div_status.done && res_from_div_q) begin
      res_good_q <= div_match;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == acfr_pkg::ST_EMIT && !suppress_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == acfr_pkg::ST_EMIT && !suppress_q && out_free) begin
      out_byte_q    <= res_byte_q;
      out_carries_q <= res_carries_q;
      out_end_q     <= res_end_q;
      out_good_q    <= res_good_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_byte_q;
  assign carries_byte_o = out_carries_q;
  assign frame_end_o    = out_end_q;
  assign frame_good_o   = out_good_q;

endmodule

// ----- rtl/acfr_serial_add.sv -----
// bit-serial accumulator: adds up to three bytes into the running sum
module acfr_serial_add (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  acfr_pkg::acfr_add_ctrl_t   ctrl_i,
  input  logic [7:0]                 op_a_i,
  input  logic [7:0]                 op_b_i,
  input  logic [7:0]                 op_c_i,
  output acfr_pkg::acfr_status_t     status_o,
  output logic [acfr_pkg::SUM_W-1:0] sum_o
);

  logic [acfr_pkg::SUM_W-1:0] acc_q, acc_d;
  logic [7:0]                 opa_q, opb_q, opc_q;
  logic [1:0]                 carry_q;
  logic [acfr_pkg::CNT_W-1:0] cnt_q;
  logic                       busy_q, done_q, clr_q;
  logic                       acc_bit;
  logic [2:0]                 total;

  // one bit of the sum per cycle, lsb first
  always_comb begin
    acc_bit = acc_q[0] & ~clr_q;
    total   = {2'b00, acc_bit} + {2'b00, opa_q[0]} + {2'b00, opb_q[0]}
            + {2'b00, opc_q[0]} + {1'b0, carry_q};
    acc_d   = {total[0], acc_q[acfr_pkg::SUM_W-1:1]};
  end

  // step counter and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      clr_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        clr_q  <= ctrl_i.clear;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == acfr_pkg::LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // accumulator and operand shift registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (busy_q && !ctrl_i.start) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      opa_q   <= op_a_i;
      opb_q   <= op_b_i;
      opc_q   <= op_c_i;
      carry_q <= 2'b00;
    end else if (busy_q) begin
      opa_q   <= {1'b0, opa_q[7:1]};
      opb_q   <= {1'b0, opb_q[7:1]};
      opc_q   <= {1'b0, opc_q[7:1]};
      carry_q <= total[2:1];
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign sum_o         = acc_q;

endmodule

// ----- rtl/acfr_serial_div.sv -----
// restoring divider, one quotient bit per cycle, compares quotient with the check byte
module acfr_serial_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [acfr_pkg::SUM_W-1:0] dividend_i,
  input  logic [8:0]                 divisor_i,
  input  logic [7:0]                 expect_i,
  output acfr_pkg::acfr_status_t     status_o,
  output logic                       match_o
);

  logic [acfr_pkg::SUM_W-1:0] dq_q;
  logic [8:0]                 rem_q, div_q;
  logic [7:0]                 exp_q;
  logic [acfr_pkg::CNT_W-1:0] cnt_q;
  logic                       busy_q, done_q;
  logic [9:0]                 trial, diff;
  logic                       q_bit;
  logic [8:0]                 rem_d;

  // trial subtraction of the shifted remainder
  always_comb begin
    trial = {rem_q, dq_q[acfr_pkg::SUM_W-1]};
    diff  = trial - {1'b0, div_q};
    q_bit = (trial >= {1'b0, div_q});
    rem_d = q_bit ? diff[8:0] : trial[8:0];
  end

  // step counter and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == acfr_pkg::LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top, quotient shifts in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
      exp_q <= expect_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[acfr_pkg::SUM_W-2:0], q_bit};
      rem_q <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign match_o       = (dq_q == {{(acfr_pkg::SUM_W-8){1'b0}}, exp_q});

endmodule
